// ===== sv/iqp_pkg.sv =====
`default_nettype none
package iqp_pkg;

    localparam int SAMPLE_WIDTH     = 24;
    localparam int FULL_SCALE_SHIFT = 20;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 14;
    localparam int FMT_W     = 2;
    localparam int REG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // gained magnitude: |x| * gain >> 14
    localparam int PROD_W = SAMPLE_WIDTH + GAIN_W;
    localparam int G_W    = PROD_W - GAIN_FRAC;
    // clamped magnitude holds 0 .. 2^FULL_SCALE_SHIFT
    localparam int C_W    = FULL_SCALE_SHIFT + 1;
    localparam int GX_W   = (G_W > FULL_SCALE_SHIFT + 1) ? G_W : FULL_SCALE_SHIFT + 2;
    localparam int SCALE_W = 31;
    localparam int SP_W    = C_W + SCALE_W;
    localparam int CODE_W  = 32;

    localparam int PEAK_W = 26;
    localparam int PX_W   = (G_W > PEAK_W) ? G_W : PEAK_W;
    localparam int CNT_W  = 40;
    localparam int VB_W   = 4;
    localparam int WORD_W = 64;

    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // sample_format codes; the unused code packs as int8
    localparam logic [FMT_W-1:0] FMT_INT32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_INT16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_INT8  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_INT32 = 31'h7FFF_FFFF;
    localparam logic [SCALE_W-1:0] SCALE_INT16 = 31'd32767;
    localparam logic [SCALE_W-1:0] SCALE_INT8  = 31'd127;

    localparam logic [VB_W-1:0] VB_INT32 = 4'd8;
    localparam logic [VB_W-1:0] VB_INT16 = 4'd4;
    localparam logic [VB_W-1:0] VB_INT8  = 4'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENDIAN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRACK  = 2'd3;

    localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_INT16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    typedef struct packed {
        logic [FMT_W-1:0]  fmt;
        logic              big_endian;
        logic [GAIN_W-1:0] gain;
        logic              track_clips;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] bytes;   // component code, already in wire byte order
        logic              clip;
        logic [G_W-1:0]    mag;     // gained magnitude before clamping
    } t_lane_res;

endpackage
`default_nettype wire

// ===== sv/iqp_if.sv =====
`default_nettype none
interface iqp_in_if;
    import iqp_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] i_sample;
    logic signed [SAMPLE_WIDTH-1:0] q_sample;

    modport source (output valid, output i_sample, output q_sample, input ready);
    modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

interface iqp_out_if;
    import iqp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packed_word;
    logic [VB_W-1:0]   valid_bytes;
    logic [PEAK_W-1:0] peak_level;
    logic [CNT_W-1:0]  clip_count;
    logic [CNT_W-1:0]  sample_total;

    modport source (output valid, output packed_word, output valid_bytes,
                    output peak_level, output clip_count, output sample_total,
                    input ready);
    modport sink   (input valid, input packed_word, input valid_bytes,
                    input peak_level, input clip_count, input sample_total,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/iq_sample_quantizer_packer.sv =====
// An accepted input word passes the stage A, B and C registers and the merge register to its output word.
// Throughput: one complex sample per cycle; an output stall holds the whole
// pipeline (magnitude, gain multiply, scale multiply, merge) in place.
// Reset (synchronous, active low): pipeline emptied, registers back to int16,
// little-endian, unity gain, clip tracking off; peak and counters cleared.
`default_nettype none
module iq_sample_quantizer_packer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [iqp_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [iqp_pkg::CFG_W-1:0]       i_cfg_data,
    iqp_in_if.sink                               i_in,
    iqp_out_if.source                            o_out
);
    import iqp_pkg::*;

    t_cfg      r_cfg;
    logic [2:0] r_v;     // stage A, B, C valid
    logic      r_ov;
    logic      w_adv;
    t_lane_res w_res_i, w_res_q;

    assign w_adv      = !(r_ov && !o_out.ready);
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt         <= FMT_RESET;
            r_cfg.big_endian  <= 1'b0;
            r_cfg.gain        <= GAIN_RESET;
            r_cfg.track_clips <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FORMAT: r_cfg.fmt         <= i_cfg_data[FMT_W-1:0];
                REG_ENDIAN: r_cfg.big_endian  <= i_cfg_data[0];
                REG_GAIN:   r_cfg.gain        <= i_cfg_data[GAIN_W-1:0];
                REG_TRACK:  r_cfg.track_clips <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v  <= {r_v[1:0], i_in.valid};
            r_ov <= r_v[2];
        end
    end

    iqp_lane u_lane_i (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (r_cfg),
        .i_x   (i_in.i_sample),
        .o_res (w_res_i)
    );

    iqp_lane u_lane_q (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (r_cfg),
        .i_x   (i_in.q_sample),
        .o_res (w_res_q)
    );

    iqp_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_adv && r_v[2]),
        .i_cfg          (r_cfg),
        .i_res_i        (w_res_i),
        .i_res_q        (w_res_q),
        .o_word         (o_out.packed_word),
        .o_valid_bytes  (o_out.valid_bytes),
        .o_peak         (o_out.peak_level),
        .o_clip_count   (o_out.clip_count),
        .o_sample_total (o_out.sample_total)
    );

    assign o_out.valid = r_ov;

endmodule
`default_nettype wire

// ===== sv/iqp_lane.sv =====
`default_nettype none
module iqp_lane (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_adv,
    input  wire iqp_pkg::t_cfg                          i_cfg,
    input  wire logic signed [iqp_pkg::SAMPLE_WIDTH-1:0] i_x,
    output iqp_pkg::t_lane_res                          o_res
);
    import iqp_pkg::*;

    localparam logic [GX_W-1:0] FS_X = GX_W'(1) << FULL_SCALE_SHIFT;
    localparam logic [C_W-1:0]  FS_C = C_W'(1) << FULL_SCALE_SHIFT;

    // stage A: sign and magnitude
    logic [SAMPLE_WIDTH-1:0] r_mag, n_mag;
    logic                    r_neg_a;
    // stage B: gained magnitude
    logic [G_W-1:0]          r_g, n_g;
    logic                    r_neg_b;
    // stage C: scaled code magnitude
    logic [SCALE_W-1:0]      r_q, n_q;
    logic                    r_neg_c, r_clip, n_clip;
    logic [G_W-1:0]          r_gc;

    logic [PROD_W-1:0]       w_prod;
    logic [GX_W-1:0]         w_gx;
    logic [C_W-1:0]          w_c;
    logic [SCALE_W-1:0]      w_scale;
    logic [SP_W-1:0]         w_sp;
    logic [CODE_W-1:0]       w_code;

    always_comb begin
        n_mag = i_x[SAMPLE_WIDTH-1] ? (~i_x) + SAMPLE_WIDTH'(1) : i_x;
    end

    always_comb begin
        w_prod = PROD_W'(r_mag) * PROD_W'(i_cfg.gain);
        n_g    = w_prod[PROD_W-1:GAIN_FRAC];
    end

    always_comb begin
        w_gx   = GX_W'(r_g);
        n_clip = w_gx > FS_X;
        w_c    = n_clip ? FS_C : w_gx[C_W-1:0];
        case (i_cfg.fmt)
            FMT_INT32: w_scale = SCALE_INT32;
            FMT_INT16: w_scale = SCALE_INT16;
            default:   w_scale = SCALE_INT8;
        endcase
        w_sp = SP_W'(w_c) * SP_W'(w_scale);
        n_q  = w_sp[FULL_SCALE_SHIFT+SCALE_W-1:FULL_SCALE_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag   <= n_mag;
            r_neg_a <= i_x[SAMPLE_WIDTH-1];
            r_g     <= n_g;
            r_neg_b <= r_neg_a;
            r_q     <= n_q;
            r_neg_c <= r_neg_b;
            r_clip  <= n_clip;
            r_gc    <= r_g;
        end
    end

    // sign restore and byte order
    always_comb begin
        w_code = r_neg_c ? CODE_W'(0) - {1'b0, r_q} : {1'b0, r_q};
        o_res.clip = r_clip;
        o_res.mag  = r_gc;
        case (i_cfg.fmt)
            FMT_INT32: o_res.bytes = i_cfg.big_endian
                ? {w_code[7:0], w_code[15:8], w_code[23:16], w_code[31:24]} : w_code;
            FMT_INT16: o_res.bytes = i_cfg.big_endian
                ? {16'd0, w_code[7:0], w_code[15:8]} : {16'd0, w_code[15:0]};
            default:   o_res.bytes = {24'd0, w_code[7:0]};
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/iqp_merge.sv =====
`default_nettype none
module iqp_merge (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire iqp_pkg::t_cfg                 i_cfg,
    input  wire iqp_pkg::t_lane_res            i_res_i,
    input  wire iqp_pkg::t_lane_res            i_res_q,
    output logic [iqp_pkg::WORD_W-1:0]         o_word,
    output logic [iqp_pkg::VB_W-1:0]           o_valid_bytes,
    output logic [iqp_pkg::PEAK_W-1:0]         o_peak,
    output logic [iqp_pkg::CNT_W-1:0]          o_clip_count,
    output logic [iqp_pkg::CNT_W-1:0]          o_sample_total
);
    import iqp_pkg::*;

    logic [WORD_W-1:0] r_word, n_word;
    logic [VB_W-1:0]   r_vb, n_vb;
    logic [PEAK_W-1:0] r_peak, n_peak;
    logic [CNT_W-1:0]  r_clip, n_clip;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic [G_W-1:0]    w_m;
    logic [PX_W-1:0]   w_mx;
    logic [PEAK_W-1:0] w_msat;
    logic [1:0]        w_add;

    always_comb begin
        case (i_cfg.fmt)
            FMT_INT32: begin
                n_word = {i_res_q.bytes, i_res_i.bytes};
                n_vb   = VB_INT32;
            end
            FMT_INT16: begin
                n_word = {32'd0, i_res_q.bytes[15:0], i_res_i.bytes[15:0]};
                n_vb   = VB_INT16;
            end
            default: begin
                n_word = {48'd0, i_res_q.bytes[7:0], i_res_i.bytes[7:0]};
                n_vb   = VB_INT8;
            end
        endcase
    end

    always_comb begin
        w_m    = (i_res_i.mag > i_res_q.mag) ? i_res_i.mag : i_res_q.mag;
        w_mx   = PX_W'(w_m);
        w_msat = (w_mx > PX_W'(PEAK_MAX)) ? PEAK_MAX : w_mx[PEAK_W-1:0];
        n_peak = (w_msat > r_peak) ? w_msat : r_peak;

        w_add = {1'b0, i_res_i.clip} + {1'b0, i_res_q.clip};
        if (!i_cfg.track_clips) begin
            n_clip = r_clip;
        end else if (r_clip > CNT_MAX - CNT_W'(w_add)) begin
            n_clip = CNT_MAX;
        end else begin
            n_clip = r_clip + CNT_W'(w_add);
        end

        n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_clip <= '0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_peak <= n_peak;
            r_clip <= n_clip;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
            r_vb   <= n_vb;
        end
    end

    assign o_word         = r_word;
    assign o_valid_bytes  = r_vb;
    assign o_peak         = r_peak;
    assign o_clip_count   = r_clip;
    assign o_sample_total = r_cnt;

endmodule
`default_nettype wire

// ===== sv/iqp_checker.sv =====
`default_nettype none
module iqp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         i_ready,
    input wire logic [iqp_pkg::WORD_W-1:0]   i_word,
    input wire logic [iqp_pkg::VB_W-1:0]     i_vb,
    input wire logic [iqp_pkg::PEAK_W-1:0]   i_peak,
    input wire logic [iqp_pkg::CNT_W-1:0]    i_clip_count,
    input wire logic [iqp_pkg::CNT_W-1:0]    i_sample_total
);
    import iqp_pkg::*;

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output word dropped while stalled");

    // bytes past the valid count are zero
    a_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_vb == VB_INT32)
                 || (i_vb == VB_INT16 && i_word[63:32] == 32'd0)
                 || (i_vb == VB_INT8 && i_word[63:16] == 48'd0))
        else $error("bad byte count or stray bytes");

    // consecutive words count up by one unless saturated
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready) ##1 i_valid |->
            (i_sample_total == $past(i_sample_total) + CNT_W'(1))
            || ($past(i_sample_total) == CNT_MAX && i_sample_total == CNT_MAX))
        else $error("sample count step wrong");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready) ##1 i_valid |-> i_peak >= $past(i_peak))
        else $error("peak level decreased");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready) ##1 i_valid |->
            (i_clip_count >= $past(i_clip_count))
            && (i_clip_count - $past(i_clip_count) <= CNT_W'(2)))
        else $error("clip count step out of range");

endmodule

bind iq_sample_quantizer_packer iqp_checker u_iqp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_word         (o_out.packed_word),
    .i_vb           (o_out.valid_bytes),
    .i_peak         (o_out.peak_level),
    .i_clip_count   (o_out.clip_count),
    .i_sample_total (o_out.sample_total)
);
`default_nettype wire

// ===== tb/tb_iq_sample_quantizer_packer.sv =====
`default_nettype none
module tb_iq_sample_quantizer_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import iqp_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;
    localparam longint unsigned FULL_SCALE = 64'd1 << FULL_SCALE_SHIFT;
    localparam int RANDOM_PHASES = 14;
    localparam int ITEMS_PER_PHASE = 125;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [VB_W-1:0]   nbytes;
        logic [PEAK_W-1:0] peak;
        logic [CNT_W-1:0]  clips;
        logic [CNT_W-1:0]  samples;
    } t_quant_word;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    iqp_in_if  in_if ();
    iqp_out_if out_if ();

    iq_sample_quantizer_packer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // shadow of the block's registers and running state
    logic [FMT_W-1:0]  model_fmt;
    logic              model_be;
    logic [GAIN_W-1:0] model_gain;
    logic              model_track;
    logic [PEAK_W-1:0] model_peak;
    logic [CNT_W-1:0]  model_clips;
    logic [CNT_W-1:0]  model_samples;

    t_quant_word expected_words[$];

    int errors;
    int items_sent;
    int words_checked;
    int cfg_writes;
    int in_stall_cycles;
    int tx_gap_max;
    int rx_stall_max;
    int rx_hold_cycles;

    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && in_if.valid && !in_if.ready) begin
            in_stall_cycles <= in_stall_cycles + 1;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic [G_W-1:0] gained_mag(input logic [SAMPLE_WIDTH-1:0] x);
        logic [SAMPLE_WIDTH-1:0] mag;
        logic [PROD_W-1:0]       prod;
        mag  = x[SAMPLE_WIDTH-1] ? (~x + 1'b1) : x;
        prod = PROD_W'(mag) * PROD_W'(model_gain);
        return prod[PROD_W-1:GAIN_FRAC];
    endfunction

    function automatic longint unsigned component_code(input logic [G_W-1:0] g,
                                                       input logic negative);
        longint unsigned c;
        longint unsigned q;
        longint unsigned scale;
        case (model_fmt)
            FMT_INT32: scale = 64'd2147483647;
            FMT_INT16: scale = 64'd32767;
            default:   scale = 64'd127;
        endcase
        c = (64'(g) > FULL_SCALE) ? FULL_SCALE : 64'(g);
        q = (c * scale) >> FULL_SCALE_SHIFT;
        return (negative && g != '0) ? (~q + 64'd1) : q;
    endfunction

    function automatic longint unsigned pack_lane(input longint unsigned code, input int nb);
        longint unsigned r;
        int src;
        r = 0;
        for (int k = 0; k < nb; k++) begin
            src = model_be ? (nb - 1 - k) : k;
            r |= ((code >> (8 * src)) & 64'hFF) << (8 * k);
        end
        return r;
    endfunction

    function automatic t_quant_word predict_sample(input logic [SAMPLE_WIDTH-1:0] i_s,
                                                   input logic [SAMPLE_WIDTH-1:0] q_s);
        t_quant_word r;
        logic [G_W-1:0] gi;
        logic [G_W-1:0] gq;
        logic [G_W-1:0] m;
        int add;
        int nb;
        gi = gained_mag(i_s);
        gq = gained_mag(q_s);
        m  = (gi > gq) ? gi : gq;
        if (PX_W'(m) > PX_W'(PEAK_MAX)) m = G_W'(PEAK_MAX);
        if (PEAK_W'(m) > model_peak) model_peak = PEAK_W'(m);
        if (model_track) begin
            add = int'(64'(gi) > FULL_SCALE) + int'(64'(gq) > FULL_SCALE);
            if (CNT_MAX - model_clips < CNT_W'(add)) model_clips = CNT_MAX;
            else model_clips = model_clips + CNT_W'(add);
        end
        if (model_samples < CNT_MAX) model_samples = model_samples + 1'b1;
        case (model_fmt)
            FMT_INT32: nb = 4;
            FMT_INT16: nb = 2;
            default:   nb = 1;
        endcase
        r.word = pack_lane(component_code(gi, i_s[SAMPLE_WIDTH-1]), nb)
               | (pack_lane(component_code(gq, q_s[SAMPLE_WIDTH-1]), nb) << (8 * nb));
        r.nbytes  = VB_W'(2 * nb);
        r.peak    = model_peak;
        r.clips   = model_clips;
        r.samples = model_samples;
        return r;
    endfunction

    // ---------------- drivers ----------------

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FORMAT: model_fmt   = data[FMT_W-1:0];
            REG_ENDIAN: model_be    = data[0];
            REG_GAIN:   model_gain  = data[GAIN_W-1:0];
            REG_TRACK:  model_track = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] i_s,
                               input logic [SAMPLE_WIDTH-1:0] q_s);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.i_sample <= i_s;
        in_if.q_sample <= q_s;
        do @(posedge clk); while (!in_if.ready);
        expected_words.push_back(predict_sample(i_s, q_s));
        items_sent++;
    endtask

    // stop offering, let every expected word come out, then let the pipe settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_config(input logic [FMT_W-1:0] fmt, input logic be,
                              input logic [GAIN_W-1:0] gain, input logic track);
        wait_idle();
        // upper data bits are don't-care for the narrow registers
        write_reg(REG_FORMAT, {(CFG_W-FMT_W)'($urandom), fmt});
        write_reg(REG_ENDIAN, {(CFG_W-1)'($urandom), be});
        write_reg(REG_GAIN, gain);
        write_reg(REG_TRACK, {(CFG_W-1)'($urandom), track});
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] rand_component();
        longint x;
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: x = longint'($signed(SAMPLE_WIDTH'($urandom)));
            4, 5: x = longint'(FULL_SCALE) + $urandom_range(0, 64) - 32;
            6: begin
                case ($urandom_range(0, 6))
                    0: x = 64'sd8388607;
                    1: x = -64'sd8388608;
                    2: x = 0;
                    3: x = -1;
                    4: x = 1;
                    5: x = longint'(FULL_SCALE);
                    default: x = -longint'(FULL_SCALE);
                endcase
            end
            7, 8: x = $urandom_range(0, 32'(FULL_SCALE));
            default: begin
                // land near the clip threshold for the current gain
                if (model_gain == 0) x = $urandom_range(0, 8388607);
                else x = (64'sd1 << (FULL_SCALE_SHIFT + GAIN_FRAC)) / model_gain
                         + $urandom_range(0, 4) - 2;
                if (x > 8388607) x = 8388607;
            end
        endcase
        if (pick >= 4 && pick != 6 && $urandom_range(0, 1)) x = -x;
        return SAMPLE_WIDTH'(x);
    endfunction

    // ---------------- result checking ----------------

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
                                 input logic [WORD_W-1:0] act_v);
        errors++;
        if (errors <= 10) begin
            $display("MISMATCH word %0d %s: expected %h got %h", words_checked, what,
                     exp_v, act_v);
        end
    endtask

    initial begin : result_checker
        int stall;
        t_quant_word e;
        out_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid);
            if (expected_words.size() == 0) begin
                note_mismatch("unexpected", '0, out_if.packed_word);
            end else begin
                e = expected_words.pop_front();
                if (out_if.packed_word !== e.word)
                    note_mismatch("packed_word", e.word, out_if.packed_word);
                if (out_if.valid_bytes !== e.nbytes)
                    note_mismatch("valid_bytes", WORD_W'(e.nbytes), WORD_W'(out_if.valid_bytes));
                if (out_if.peak_level !== e.peak)
                    note_mismatch("peak_level", WORD_W'(e.peak), WORD_W'(out_if.peak_level));
                if (out_if.clip_count !== e.clips)
                    note_mismatch("clip_count", WORD_W'(e.clips), WORD_W'(out_if.clip_count));
                if (out_if.sample_total !== e.samples)
                    note_mismatch("sample_total", WORD_W'(e.samples),
                                  WORD_W'(out_if.sample_total));
            end
            words_checked++;
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        // int16, little-endian, unity gain, tracking off: clipping is not counted
        send_sample(24'sd0, 24'sd0);
        send_sample(24'sd1, -24'sd1);
        send_sample(24'(FULL_SCALE), -24'(FULL_SCALE));
        send_sample(24'(FULL_SCALE + 1), -24'(FULL_SCALE + 1));
        send_sample(24'sd8388607, -24'sd8388608);
        send_sample(-24'sd524287, 24'sd12345);
    endtask

    task automatic test_formats_endian();
        logic [FMT_W-1:0] fmts [4];
        fmts = '{FMT_INT32, FMT_INT16, FMT_INT8, FMT_UNUSED};
        for (int f = 0; f < 4; f++) begin
            for (int b = 0; b < 2; b++) begin
                set_config(fmts[f], b[0], GAIN_RESET, 1'b0);
                send_sample(24'sd801429, -24'sd523517);
            end
        end
    endtask

    task automatic test_gain_extremes();
        set_config(FMT_INT32, 1'b0, 16'h0000, 1'b1);
        send_sample(24'sd8388607, -24'sd8388608);
        set_config(FMT_INT32, 1'b1, 16'hFFFF, 1'b1);
        // just under and just over full scale at maximum gain
        send_sample(24'sd262148, -24'sd262149);
        send_sample(24'sd8388607, -24'sd8388608);
    endtask

    task automatic test_clip_tracking();
        set_config(FMT_INT32, 1'b0, GAIN_RESET, 1'b1);
        send_sample(24'(FULL_SCALE), -24'(FULL_SCALE));
        send_sample(24'(FULL_SCALE + 1), 24'sd0);
        send_sample(-24'(FULL_SCALE + 1), 24'sd8388607);
    endtask

    task automatic test_output_backpressure();
        set_config(FMT_INT16, 1'b1, 16'd20000, 1'b1);
        tx_gap_max = 0;
        rx_stall_max = 0;
        rx_hold_cycles = 250;
        for (int n = 0; n < 80; n++) send_sample(rand_component(), rand_component());
    endtask

    task automatic test_random_stream();
        logic [GAIN_W-1:0] gain;
        int speeds [3];
        speeds = '{0, 3, 18};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 5)
                0: gain = GAIN_W'($urandom);
                1: gain = 16'hFFFF;
                2: gain = GAIN_W'(GAIN_RESET + $urandom_range(0, 64) - 32);
                3: gain = GAIN_W'($urandom_range(8192, 32768));
                default: gain = GAIN_W'($urandom);
            endcase
            set_config(FMT_W'(p % 4), 1'((p / 4) % 2), gain, 1'((p / 2) % 2));
            if (p % 7 == 3) begin
                tx_gap_max = 0;
                rx_stall_max = 0;
            end else begin
                tx_gap_max = speeds[$urandom_range(0, 2)];
                rx_stall_max = speeds[$urandom_range(0, 2)];
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(rand_component(), rand_component());
        end
    endtask

    initial begin : main_sequence
        errors = 0;
        items_sent = 0;
        words_checked = 0;
        cfg_writes = 0;
        in_stall_cycles = 0;
        tx_gap_max = 18;
        rx_stall_max = 18;
        rx_hold_cycles = 0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= REG_FORMAT;
        cfg_data       <= '0;
        in_if.valid    <= 1'b0;
        in_if.i_sample <= '0;
        in_if.q_sample <= '0;
        model_fmt     = FMT_RESET;
        model_be      = 1'b0;
        model_gain    = GAIN_RESET;
        model_track   = 1'b0;
        model_peak    = '0;
        model_clips   = '0;
        model_samples = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_formats_endian();
        test_gain_extremes();
        test_clip_tracking();
        test_output_backpressure();
        test_random_stream();
        wait_idle();

        errors += expected_words.size();
        $display("covered %0d samples, %0d register writes, all four format codes and both",
                 items_sent, cfg_writes);
        $display("byte orders; %0d clips counted, input held off %0d cycles",
                 model_clips, in_stall_cycles);
        if (errors == 0) begin
            $display("iq_sample_quantizer_packer verification clean");
        end else begin
            $display("iq_sample_quantizer_packer verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout: %0d samples sent, %0d words checked", items_sent, words_checked);
        $display("iq_sample_quantizer_packer verification failed");
        $finish;
    end

endmodule
`default_nettype wire
